// ----- rtl/avt_pkg.sv -----
package avt_pkg;

  // field widths
  localparam int COORD_W    = 16;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int ROW_W      = 4 * COORD_W;
  localparam int FRAC_SHIFT = 12;
  // three products of 2^30 at most plus translation and bias fit 33 bits signed
  localparam int ACC_W      = PROD_W + 1;
  localparam int Q_W        = ACC_W - FRAC_SHIFT;
  localparam int NUM_ROWS   = 3;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z = 2'd2;

  // identity matrix, zero translation
  localparam logic [ROW_W-1:0] ROW_X_RESET = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW_Y_RESET = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW_Z_RESET = 64'h0000_1000_0000_0000;

  // half an lsb of q8.8 in q.20
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = 33'sd2048;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  // one matrix row as packed in its register
  typedef struct packed {
    coord_t tr;
    coord_t cz;
    coord_t cy;
    coord_t cx;
  } row_t;

  // index 0 is the x row
  typedef row_t [NUM_ROWS-1:0] matrix_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    prod_t px;
    prod_t py;
    prod_t pz;
  } row_prod_t;

  typedef row_prod_t [NUM_ROWS-1:0] prods_t;
  typedef acc_t [NUM_ROWS-1:0]      accs_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   clipped;
  } result_t;

endpackage

// ----- rtl/avt_point_if.sv -----
interface avt_point_if;
  logic                  valid;
  logic                  ready;
  logic signed [15:0]    in_x;
  logic signed [15:0]    in_y;
  logic signed [15:0]    in_z;

  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

// ----- rtl/avt_result_if.sv -----
interface avt_result_if;
  logic                  valid;
  logic                  ready;
  logic signed [15:0]    out_x;
  logic signed [15:0]    out_y;
  logic signed [15:0]    out_z;
  logic                  clipped;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output clipped, input ready);
  modport sink (input valid, input out_x, input out_y, input out_z,
                input clipped, output ready);
endinterface

// ----- rtl/avt_cfg_if.sv -----
interface avt_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [avt_pkg::CFG_IDX_W-1:0]    idx;
  logic [avt_pkg::ROW_W-1:0]        wdata;

  modport source (output valid, output idx, output wdata, input ready);
  modport sink (input valid, input idx, input wdata, output ready);
endinterface

// ----- rtl/avt_cfg_regs.sv -----
module avt_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_valid,
  output logic                          wr_ready,
  input  logic [avt_pkg::CFG_IDX_W-1:0] wr_idx,
  input  logic [avt_pkg::ROW_W-1:0]     wr_data,
  output avt_pkg::matrix_t              mat
);

  // a write beat is always taken
  assign wr_ready = 1'b1;

  // row registers, out-of-range index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      mat[0] <= avt_pkg::row_t'(avt_pkg::ROW_X_RESET);
      mat[1] <= avt_pkg::row_t'(avt_pkg::ROW_Y_RESET);
      mat[2] <= avt_pkg::row_t'(avt_pkg::ROW_Z_RESET);
    end else if (wr_valid) begin
      unique case (wr_idx)
        avt_pkg::CFG_ROW_X: mat[0] <= avt_pkg::row_t'(wr_data);
        avt_pkg::CFG_ROW_Y: mat[1] <= avt_pkg::row_t'(wr_data);
        avt_pkg::CFG_ROW_Z: mat[2] <= avt_pkg::row_t'(wr_data);
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/avt_mul_stage.sv -----
module avt_mul_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  avt_pkg::point_t   pt,
  input  avt_pkg::matrix_t  mat,
  output logic              out_valid,
  input  logic              out_ready,
  output avt_pkg::prods_t   prods
);

  // stage moves when empty or when the next stage takes its beat
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // nine coefficient by coordinate products, q12.20
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int r = 0; r < avt_pkg::NUM_ROWS; r++) begin
        prods[r].px <= mat[r].cx * pt.x;
        prods[r].py <= mat[r].cy * pt.y;
        prods[r].pz <= mat[r].cz * pt.z;
      end
    end
  end

endmodule

// ----- rtl/avt_sum_stage.sv -----
module avt_sum_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  avt_pkg::prods_t   prods,
  input  avt_pkg::matrix_t  mat,
  output logic              out_valid,
  input  logic              out_ready,
  output avt_pkg::accs_t    accs
);

  avt_pkg::accs_t acc_next;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // products plus translation scaled to q.20 plus rounding bias
  always_comb begin
    for (int r = 0; r < avt_pkg::NUM_ROWS; r++) begin
      acc_next[r] = avt_pkg::ACC_W'(prods[r].px)
                  + avt_pkg::ACC_W'(prods[r].py)
                  + avt_pkg::ACC_W'(prods[r].pz)
                  + avt_pkg::acc_t'({{(avt_pkg::ACC_W - avt_pkg::COORD_W
                                       - avt_pkg::FRAC_SHIFT){mat[r].tr[avt_pkg::COORD_W-1]}},
                                     mat[r].tr, {avt_pkg::FRAC_SHIFT{1'b0}}})
                  + avt_pkg::ROUND_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      accs <= acc_next;
    end
  end

endmodule

// ----- rtl/avt_sat_stage.sv -----
module avt_sat_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  avt_pkg::accs_t    accs,
  output logic              out_valid,
  input  logic              out_ready,
  output avt_pkg::result_t  res
);

  logic signed [avt_pkg::Q_W-1:0]        q [avt_pkg::NUM_ROWS];
  logic [avt_pkg::NUM_ROWS-1:0]          ovf;
  avt_pkg::coord_t                       coord [avt_pkg::NUM_ROWS];
  avt_pkg::result_t                      res_next;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // floor shift to q8.8, then clamp when the top bits are not all sign
  always_comb begin
    for (int r = 0; r < avt_pkg::NUM_ROWS; r++) begin
      q[r]   = avt_pkg::Q_W'(accs[r] >>> avt_pkg::FRAC_SHIFT);
      ovf[r] = !((&q[r][avt_pkg::Q_W-1:avt_pkg::COORD_W-1]) ||
                 !(|q[r][avt_pkg::Q_W-1:avt_pkg::COORD_W-1]));
      coord[r] = ovf[r] ? {q[r][avt_pkg::Q_W-1], {(avt_pkg::COORD_W-1){!q[r][avt_pkg::Q_W-1]}}}
                        : q[r][avt_pkg::COORD_W-1:0];
    end
    res_next.x       = coord[0];
    res_next.y       = coord[1];
    res_next.z       = coord[2];
    res_next.clipped = |ovf;
  end

  // output register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res <= res_next;
    end
  end

endmodule

// ----- rtl/affine_vertex_transform.sv -----
// Affine vertex transform: each point beat (in_x, in_y, in_z, signed Q8.8) is multiplied by
// the top three rows of a homogeneous matrix with w = 1 and gives one result beat (out_x,
// out_y, out_z, signed Q8.8, rounded to nearest with ties up, saturated, clipped set when any
// coordinate saturated). Configuration index 0, 1, 2 writes row x, y, z: coefficients for x, y,
// z in bits 15:0, 31:16, 47:32 (signed Q4.12) and translation in bits 63:48 (signed Q8.8);
// other indexes are ignored, and reset loads the identity. Rows may only be rewritten while
// no point is in flight. The pipeline has three register stages (nine 16x16 multipliers, a
// 33-bit add of products, translation and rounding bias, then shift and clamp into the output
// register), and one point per cycle is sustained while the output is ready. Each stage holds
// its beat while the one after it is full and cannot pass its own beat on, so the input stays
// ready while the output waits until all three stages are occupied.
module affine_vertex_transform (
  input  logic          clk,
  input  logic          rst,
  avt_point_if.sink     pnt,
  avt_result_if.source  res,
  avt_cfg_if.sink       cfg
);

  avt_pkg::matrix_t  mat;
  avt_pkg::point_t   pt;
  avt_pkg::prods_t   prods;
  avt_pkg::accs_t    accs;
  avt_pkg::result_t  result;
  logic              mul_valid;
  logic              mul_ready;
  logic              sum_valid;
  logic              sum_ready;

  // configuration rows
  avt_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_ready (cfg.ready),
    .wr_idx   (cfg.idx),
    .wr_data  (cfg.wdata),
    .mat      (mat)
  );

  assign pt.x = pnt.in_x;
  assign pt.y = pnt.in_y;
  assign pt.z = pnt.in_z;

  // stage 1: products
  avt_mul_stage u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pnt.valid),
    .in_ready  (pnt.ready),
    .pt        (pt),
    .mat       (mat),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .prods     (prods)
  );

  // stage 2: sums
  avt_sum_stage u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .prods     (prods),
    .mat       (mat),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .accs      (accs)
  );

  // stage 3: round, clamp, output register
  avt_sat_stage u_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .accs      (accs),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .res       (result)
  );

  assign res.out_x   = result.x;
  assign res.out_y   = result.y;
  assign res.out_z   = result.z;
  assign res.clipped = result.clipped;

endmodule
